// ===== hdl/obd2q_pkg.sv =====
package obd2q_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TEXT_LEN    = 17;

  localparam logic [10:0] QUERY_ID = 11'h7DF;

  // service modes
  localparam logic [7:0] MODE_CURRENT = 8'h01;
  localparam logic [7:0] MODE_CODES   = 8'h03;
  localparam logic [7:0] MODE_CLEAR   = 8'h04;
  localparam logic [7:0] MODE_PENDING = 8'h07;
  localparam logic [7:0] MODE_INFO    = 8'h09;

  // mode 1 PIDs
  localparam logic [7:0] PID_SUP_A    = 8'h00;
  localparam logic [7:0] PID_COOLANT  = 8'h05;
  localparam logic [7:0] PID_MAP      = 8'h0B;
  localparam logic [7:0] PID_RPM      = 8'h0C;
  localparam logic [7:0] PID_SPEED    = 8'h0D;
  localparam logic [7:0] PID_INTAKE   = 8'h0F;
  localparam logic [7:0] PID_MAF      = 8'h10;
  localparam logic [7:0] PID_STD      = 8'h1C;
  localparam logic [7:0] PID_SUP_B    = 8'h20;
  localparam logic [7:0] PID_DISTANCE = 8'h21;
  localparam logic [7:0] PID_FUEL     = 8'h2F;

  // mode 9 info types
  localparam logic [7:0] INFO_SUPPORT = 8'h00;
  localparam logic [7:0] INFO_VIN     = 8'h02;
  localparam logic [7:0] INFO_CAL     = 8'h04;

  localparam logic [7:0] SVC_CURRENT = 8'h41;
  localparam logic [7:0] SVC_CODES   = 8'h43;
  localparam logic [7:0] SVC_INFO    = 8'h49;
  localparam logic [7:0] TEMP_OFFSET = 8'd40;
  localparam logic [7:0] FUEL_SCALE  = 8'd100;

  localparam logic [8*TEXT_LEN-1:0] VIN_TEXT = "SCBZK25EXYC813876";
  localparam logic [8*TEXT_LEN-1:0] CAL_TEXT = "FW00116MHZ1111111";

  typedef enum logic [2:0] {
    REG_SPEED    = 3'd0,
    REG_RPM      = 3'd1,
    REG_COOLANT  = 3'd2,
    REG_FUEL     = 3'd3,
    REG_INTAKE   = 3'd4,
    REG_MAF      = 3'd5,
    REG_MAP      = 3'd6,
    REG_DISTANCE = 3'd7
  } reg_index_t;

  typedef enum logic [4:0] {
    K_NONE,
    K_SET_FLAG,
    K_CLEAR,
    K_SUP_A,
    K_SUP_B,
    K_STD,
    K_FUEL,
    K_RPM,
    K_SPEED,
    K_INTAKE,
    K_MAF,
    K_COOLANT,
    K_MAP,
    K_DISTANCE,
    K_DTC,
    K_INFO_SUP,
    K_VIN,
    K_CAL
  } kind_t;

  typedef struct packed {
    logic        command;
    logic [10:0] frame_id;
    logic [7:0]  mode_byte;
    logic [7:0]  pid_byte;
    logic        flag_value;
  } query_t;

  typedef struct packed {
    logic [7:0] reply_byte0;
    logic [7:0] reply_byte1;
    logic [7:0] reply_byte2;
    logic [7:0] reply_byte3;
    logic [7:0] reply_byte4;
    logic [7:0] reply_byte5;
    logic [7:0] reply_byte6;
    logic [7:0] reply_byte7;
    logic       last_frame;
  } reply_t;

  function automatic kind_t classify(input query_t q, input logic flag);
    kind_t k;
    k = K_NONE;
    if (q.command) begin
      k = K_SET_FLAG;
    end else if (q.frame_id == QUERY_ID) begin
      case (q.mode_byte)
        MODE_CURRENT: begin
          case (q.pid_byte)
            PID_SUP_A:    k = K_SUP_A;
            PID_SUP_B:    k = K_SUP_B;
            PID_STD:      k = K_STD;
            PID_FUEL:     k = K_FUEL;
            PID_RPM:      k = K_RPM;
            PID_SPEED:    k = K_SPEED;
            PID_INTAKE:   k = K_INTAKE;
            PID_MAF:      k = K_MAF;
            PID_COOLANT:  k = K_COOLANT;
            PID_MAP:      k = K_MAP;
            PID_DISTANCE: k = K_DISTANCE;
            default:      k = K_NONE;
          endcase
        end
        MODE_CODES, MODE_PENDING: k = flag ? K_DTC : K_NONE;
        MODE_CLEAR: k = K_CLEAR;
        MODE_INFO: begin
          case (q.pid_byte)
            INFO_SUPPORT: k = K_INFO_SUP;
            INFO_VIN:     k = K_VIN;
            INFO_CAL:     k = K_CAL;
            default:      k = K_NONE;
          endcase
        end
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic [1:0] frame_count(input kind_t k);
    logic [1:0] n;
    case (k)
      K_NONE, K_SET_FLAG, K_CLEAR: n = 2'd0;
      K_VIN, K_CAL:                n = 2'd3;
      default:                     n = 2'd1;
    endcase
    return n;
  endfunction

  // character at position pos of the VIN or calibration ID
  function automatic logic [7:0] text_char(input logic sel_cal, input logic [4:0] pos);
    logic [7:0] c;
    c = sel_cal ? CAL_TEXT[8*(TEXT_LEN-1-int'(pos)) +: 8]
                : VIN_TEXT[8*(TEXT_LEN-1-int'(pos)) +: 8];
    return c;
  endfunction

endpackage

// ===== hdl/obd2q_query_if.sv =====
interface obd2q_query_if;
  import obd2q_pkg::*;

  logic   valid;
  logic   ready;
  query_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/obd2q_reply_if.sv =====
interface obd2q_reply_if;
  import obd2q_pkg::*;

  logic   valid;
  logic   ready;
  reply_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/obd2_query_responder.sv =====
// Each query is held in the query register and each reply frame in the output register.
// Throughput: one query per cycle when it gives no reply frame, or one frame and the output
// register is free; a VIN or calibration ID query holds the query register for its three frames.
// Reset (rst, synchronous): pipeline empty, malfunction flag clear, all sensor
// registers zero.
module obd2_query_responder (
  input  logic                               clk,
  input  logic                               rst,
  obd2q_query_if.sink                        query,
  obd2q_reply_if.source                      reply,
  input  logic                               cfg_we,
  input  logic [obd2q_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [obd2q_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import obd2q_pkg::*;

  // sensor registers
  logic [7:0]        vehicle_speed;
  logic [13:0]       engine_rpm;
  logic signed [8:0] coolant_temp;
  logic [7:0]        fuel_level;
  logic signed [8:0] intake_temp;
  logic [15:0]       maf_rate;
  logic [7:0]        manifold_pressure;
  logic [15:0]       distance_with_mil;

  logic       malfunction_flag;
  logic       q_valid;
  query_t     q;
  logic [1:0] idx;
  logic       out_valid;
  reply_t     out_data;

  kind_t      kind;
  logic [1:0] nframes;
  logic       frame_last;
  logic       out_free;
  logic       emit;
  logic       retire;
  logic [7:0] b [8];
  reply_t     frame;

  logic [14:0] fuel_prod;
  logic [15:0] fuel_sum;
  logic [15:0] rpm_x4;
  logic        sel_cal;

  assign kind       = classify(q, malfunction_flag);
  assign nframes    = frame_count(kind);
  assign frame_last = (idx == nframes - 2'd1);
  assign out_free   = !out_valid || reply.ready;
  assign emit       = q_valid && (nframes != 2'd0) && out_free;
  assign retire     = q_valid && ((nframes == 2'd0) || (emit && frame_last));

  assign query.ready = !q_valid || retire;
  assign reply.valid = out_valid;
  assign reply.data  = out_data;

  // 100*x/255 via reciprocal: floor(y/255) = (y + (y>>8) + 1) >> 8 for y < 65535
  assign fuel_prod = 15'(fuel_level * FUEL_SCALE);
  assign fuel_sum  = 16'(fuel_prod) + 16'(fuel_prod[14:8]) + 16'd1;
  assign rpm_x4    = {engine_rpm, 2'b00};
  assign sel_cal   = (kind == K_CAL);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      b[j] = 8'h00;
    end
    b[1] = SVC_CURRENT;
    b[2] = q.pid_byte;
    case (kind)
      K_SUP_A: begin
        b[0] = 8'h06; b[2] = 8'h00; b[3] = 8'h08; b[4] = 8'h3B; b[6] = 8'h01;
      end
      K_SUP_B: begin
        b[0] = 8'h06; b[2] = 8'h20; b[3] = 8'h80; b[4] = 8'h02;
      end
      K_STD: begin
        b[0] = 8'h04; b[3] = 8'h0A;
      end
      K_FUEL: begin
        b[0] = 8'h03; b[3] = fuel_sum[15:8];
      end
      K_RPM: begin
        b[0] = 8'h04; b[3] = rpm_x4[15:8]; b[4] = rpm_x4[7:0];
      end
      K_SPEED: begin
        b[0] = 8'h03; b[3] = vehicle_speed;
      end
      K_INTAKE: begin
        b[0] = 8'h03; b[3] = 8'(intake_temp[7:0] + TEMP_OFFSET);
      end
      K_COOLANT: begin
        b[0] = 8'h03; b[3] = 8'(coolant_temp[7:0] + TEMP_OFFSET);
      end
      K_MAF: begin
        b[0] = 8'h04; b[3] = maf_rate[15:8]; b[4] = maf_rate[7:0];
      end
      K_MAP: begin
        b[0] = 8'h03; b[3] = manifold_pressure;
      end
      K_DISTANCE: begin
        b[0] = 8'h04; b[3] = distance_with_mil[15:8]; b[4] = distance_with_mil[7:0];
      end
      K_DTC: begin
        b[0] = 8'h06; b[1] = SVC_CODES; b[2] = 8'h02; b[3] = 8'h02;
        b[4] = 8'h61; b[5] = 8'h07;
      end
      K_INFO_SUP: begin
        b[0] = 8'h06; b[1] = SVC_INFO; b[2] = 8'h00; b[3] = 8'h28; b[4] = 8'h28;
      end
      K_VIN, K_CAL: begin
        case (idx)
          2'd0: begin
            b[0] = 8'd16; b[1] = 8'd20; b[2] = 8'd73; b[3] = q.pid_byte; b[4] = 8'd1;
            b[5] = text_char(sel_cal, 5'd0);
            b[6] = text_char(sel_cal, 5'd1);
            b[7] = text_char(sel_cal, 5'd2);
          end
          2'd1: begin
            b[0] = 8'd33;
            for (int j = 1; j < 8; j++) begin
              b[j] = text_char(sel_cal, 5'(j + 2));
            end
          end
          default: begin
            b[0] = 8'd34;
            for (int j = 1; j < 8; j++) begin
              b[j] = text_char(sel_cal, 5'(j + 9));
            end
          end
        endcase
      end
      default: begin
        b[1] = SVC_CURRENT;
      end
    endcase
    frame.reply_byte0 = b[0];
    frame.reply_byte1 = b[1];
    frame.reply_byte2 = b[2];
    frame.reply_byte3 = b[3];
    frame.reply_byte4 = b[4];
    frame.reply_byte5 = b[5];
    frame.reply_byte6 = b[6];
    frame.reply_byte7 = b[7];
    frame.last_frame  = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid           <= 1'b0;
      idx               <= 2'd0;
      malfunction_flag  <= 1'b0;
      out_valid         <= 1'b0;
      vehicle_speed     <= '0;
      engine_rpm        <= '0;
      coolant_temp      <= '0;
      fuel_level        <= '0;
      intake_temp       <= '0;
      maf_rate          <= '0;
      manifold_pressure <= '0;
      distance_with_mil <= '0;
    end else begin
      if (query.valid && query.ready) begin
        q_valid <= 1'b1;
        q       <= query.data;
      end else if (retire) begin
        q_valid <= 1'b0;
      end

      if (retire) begin
        idx <= 2'd0;
      end else if (emit) begin
        idx <= idx + 2'd1;
      end

      // flag changes take effect when the query leaves the query register
      if (retire && kind == K_SET_FLAG) begin
        malfunction_flag <= q.flag_value;
      end else if (retire && kind == K_CLEAR) begin
        malfunction_flag <= 1'b0;
      end

      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= frame;
      end else if (reply.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_SPEED:    vehicle_speed     <= cfg_data[7:0];
          REG_RPM:      engine_rpm        <= cfg_data[13:0];
          REG_COOLANT:  coolant_temp      <= cfg_data[8:0];
          REG_FUEL:     fuel_level        <= cfg_data[7:0];
          REG_INTAKE:   intake_temp       <= cfg_data[8:0];
          REG_MAF:      maf_rate          <= cfg_data[15:0];
          REG_MAP:      manifold_pressure <= cfg_data[7:0];
          REG_DISTANCE: distance_with_mil <= cfg_data[15:0];
          default:      vehicle_speed     <= vehicle_speed;
        endcase
      end
    end
  end

endmodule
